/* hdl/ppu_pkg.sv */
// Package for the picture processor CPU register port.
// Holds the transaction types, command codes and register numbers; no dependencies.
`default_nettype none

package ppu_pkg;

	// command codes
	localparam logic [1:0] CMD_READ   = 2'd0;
	localparam logic [1:0] CMD_WRITE  = 2'd1;
	localparam logic [1:0] CMD_STATUS = 2'd2;

	// register numbers (CPU address modulo 8)
	localparam logic [2:0] REG_CTRL   = 3'd0;
	localparam logic [2:0] REG_MASK   = 3'd1;
	localparam logic [2:0] REG_STATUS = 3'd2;
	localparam logic [2:0] REG_OAMADR = 3'd3;
	localparam logic [2:0] REG_OAMDAT = 3'd4;
	localparam logic [2:0] REG_SCROLL = 3'd5;
	localparam logic [2:0] REG_ADDR   = 3'd6;
	localparam logic [2:0] REG_DATA   = 3'd7;

	// data reads at or above the palette base bypass the read buffer
	localparam logic [15:0] PALETTE_BASE = 16'h3F00;

	typedef struct packed {
		logic [1:0] command;
		logic [2:0] reg_index;
		logic [7:0] write_data;
		logic [7:0] vram_data;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [15:0] vram_address;
		logic        vram_write;
		logic [7:0]  vram_write_data;
		logic        nmi;
		logic [2:0]  fine_x_scroll;
	} out_item_t;

endpackage

`default_nettype wire

/* hdl/ppu_if.sv */
// Handshake channel interfaces for the register port: request and result.
// No dependencies.
`default_nettype none

interface ppu_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [2:0] reg_index;
	logic [7:0] write_data;
	logic [7:0] vram_data;

	modport source (output valid, command, reg_index, write_data, vram_data, input ready);
	modport sink (input valid, command, reg_index, write_data, vram_data, output ready);
endinterface

interface ppu_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic [15:0] vram_address;
	logic        vram_write;
	logic [7:0]  vram_write_data;
	logic        nmi;
	logic [2:0]  fine_x_scroll;

	modport source (output valid, read_data, vram_address, vram_write, vram_write_data, nmi,
		fine_x_scroll, input ready);
	modport sink (input valid, read_data, vram_address, vram_write, vram_write_data, nmi,
		fine_x_scroll, output ready);
endinterface

`default_nettype wire

/* hdl/ppu_in_stage.sv */
// Input register stage: captures one request transaction per cycle unless stalled.
// Depends on ppu_pkg.
`default_nettype none

module ppu_in_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire ppu_pkg::in_item_t in_item,
	input  wire logic             advance,
	output logic                  valid_s1,
	output ppu_pkg::in_item_t     item_s1
);
	import ppu_pkg::*;

	// stage accepts when empty or when its content moves on this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end
endmodule

`default_nettype wire

/* hdl/ppu_reg_core.sv */
// Register file and loopy scroll/address logic; builds one result per request.
// Depends on ppu_pkg.
`default_nettype none

module ppu_reg_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire ppu_pkg::in_item_t item,
	output ppu_pkg::out_item_t     result
);
	import ppu_pkg::*;

	logic [7:0]  control_q, mask_q, status_q, sprite_addr_q, sprite_data_q, rbuf_q;
	logic [14:0] t_q;
	logic [15:0] v_q;
	logic [2:0]  fine_x_q;
	logic        toggle_q;

	logic [7:0]  control_d, mask_d, status_d, sprite_addr_d, sprite_data_d, rbuf_d;
	logic [14:0] t_d;
	logic [15:0] v_d;
	logic [2:0]  fine_x_d;
	logic        toggle_d;
	logic [15:0] v_step;
	logic [7:0]  d;

	assign d      = item.write_data;
	assign v_step = control_q[2] ? 16'd32 : 16'd1;

	// next state and result for the request in stage 1
	always_comb begin
		control_d     = control_q;
		mask_d        = mask_q;
		status_d      = status_q;
		sprite_addr_d = sprite_addr_q;
		sprite_data_d = sprite_data_q;
		rbuf_d        = rbuf_q;
		t_d           = t_q;
		v_d           = v_q;
		fine_x_d      = fine_x_q;
		toggle_d      = toggle_q;
		result        = '0;
		result.vram_address = v_q;

		case (item.command)
			CMD_READ: begin
				case (item.reg_index)
					REG_STATUS: begin
						result.read_data = status_q;
						status_d[7]      = 1'b0;
						toggle_d         = 1'b0;
					end
					REG_OAMDAT: result.read_data = sprite_data_q;
					REG_DATA: begin
						result.read_data = (v_q >= PALETTE_BASE) ? item.vram_data : rbuf_q;
						rbuf_d           = item.vram_data;
						v_d              = v_q + v_step;
					end
					default: ;
				endcase
			end
			CMD_WRITE: begin
				case (item.reg_index)
					REG_CTRL: begin
						control_d     = d;
						t_d[11:10]    = d[1:0];
						result.nmi    = !control_q[7] && d[7] && status_q[7];
					end
					REG_MASK:   mask_d = d;
					REG_OAMADR: sprite_addr_d = d;
					REG_OAMDAT: begin
						sprite_data_d = d;
						sprite_addr_d = sprite_addr_q + 8'd1;
					end
					REG_SCROLL: begin
						if (toggle_q) begin
							t_d[14:12] = d[2:0];
							t_d[9:5]   = d[7:3];
						end else begin
							fine_x_d = d[2:0];
							t_d[4:0] = d[7:3];
						end
						toggle_d = !toggle_q;
					end
					REG_ADDR: begin
						if (toggle_q) begin
							t_d[7:0] = d;
							v_d      = {1'b0, t_q[14:8], d};
						end else begin
							t_d[14]   = 1'b0;
							t_d[13:8] = d[5:0];
						end
						toggle_d = !toggle_q;
					end
					REG_DATA: begin
						result.vram_write      = 1'b1;
						result.vram_write_data = d;
						v_d                    = v_q + v_step;
					end
					default: ;
				endcase
			end
			CMD_STATUS: status_d = d;
			default: ;
		endcase

		result.fine_x_scroll = fine_x_d;
	end

	// architectural state updates once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q     <= '0;
			mask_q        <= '0;
			status_q      <= '0;
			sprite_addr_q <= '0;
			sprite_data_q <= '0;
			rbuf_q        <= '0;
			t_q           <= '0;
			v_q           <= '0;
			fine_x_q      <= '0;
			toggle_q      <= 1'b0;
		end else if (fire) begin
			control_q     <= control_d;
			mask_q        <= mask_d;
			status_q      <= status_d;
			sprite_addr_q <= sprite_addr_d;
			sprite_data_q <= sprite_data_d;
			rbuf_q        <= rbuf_d;
			t_q           <= t_d;
			v_q           <= v_d;
			fine_x_q      <= fine_x_d;
			toggle_q      <= toggle_d;
		end
	end
endmodule

`default_nettype wire

/* hdl/ppu_out_stage.sv */
// Result register: holds one result transaction until the sink takes it.
// Depends on ppu_pkg.
`default_nettype none

module ppu_out_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire ppu_pkg::out_item_t result,
	output logic                    can_load,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output ppu_pkg::out_item_t      out_item
);
	import ppu_pkg::*;

	out_item_t item_q;
	logic      valid_q;

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			item_q <= result;
		end
	end
endmodule

`default_nettype wire

/* hdl/ppu_cpu_register_port.sv */
// Top level of the picture processor CPU register port.
// Depends on ppu_pkg, ppu_if, ppu_in_stage, ppu_reg_core and ppu_out_stage.
//
//   channel   direction  payload
//   req       in         command, reg_index, write_data, vram_data
//   rsp       out        read_data, vram_address, vram_write, vram_write_data,
//                        nmi, fine_x_scroll
//
// One transaction per cycle sustained while the sink takes results; a request
// passes through the input register, then the result register, before its
// result is offered.
// Register state updates when a request moves from the input register into
// the result register. Reset clears the core register state and both valid flags.
// A stalled result holds in the result register; the input register still takes
// a request while it is empty or the result register is free or being drained.
`default_nettype none

module ppu_cpu_register_port (
	input  wire logic clk,
	input  wire logic arst_n,
	ppu_in_if.sink    req,
	ppu_out_if.source rsp
);
	import ppu_pkg::*;

	in_item_t  in_item, item_s1;
	out_item_t result, out_item;
	logic      valid_s1, can_load;

	assign in_item.command    = req.command;
	assign in_item.reg_index  = req.reg_index;
	assign in_item.write_data = req.write_data;
	assign in_item.vram_data  = req.vram_data;

	ppu_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_item  (in_item),
		.advance  (can_load),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ppu_reg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (valid_s1 && can_load),
		.item   (item_s1),
		.result (result)
	);

	ppu_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.result    (result),
		.can_load  (can_load),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_item  (out_item)
	);

	assign rsp.read_data       = out_item.read_data;
	assign rsp.vram_address    = out_item.vram_address;
	assign rsp.vram_write      = out_item.vram_write;
	assign rsp.vram_write_data = out_item.vram_write_data;
	assign rsp.nmi             = out_item.nmi;
	assign rsp.fine_x_scroll   = out_item.fine_x_scroll;
endmodule

`default_nettype wire
